// File: rtl/hvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hvn_pkg;

  // Map geometry.
  localparam int CHUNK  = 64;
  localparam int TW     = $clog2(CHUNK);
  localparam int VW     = 7;
  localparam int DEPTH  = 3 * CHUNK;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths.
  localparam int HW        = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PXW       = 22;
  localparam int PYW       = 16;
  localparam int NW        = 16;
  localparam int NYW       = 15;

  // Shared divider and square root unit sizes.
  localparam int DIV_NW   = 48;
  localparam int DIV_DW   = 34;
  localparam int DIV_CW   = $clog2(DIV_NW + 1);
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int SQ_CW    = $clog2(SQ_STEPS + 1);
  localparam int SLOPE_W  = 32;
  localparam int LEN_W    = 33;
  localparam int DEN_W    = 25;

  // Neighbor taps read from the row store for one vertex.
  localparam logic [2:0] TAP_H = 3'd0;
  localparam logic [2:0] TAP_L = 3'd1;
  localparam logic [2:0] TAP_R = 3'd2;
  localparam logic [2:0] TAP_U = 3'd3;
  localparam logic [2:0] TAP_D = 3'd4;
  localparam int         NTAPS = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIZE  = 2'd0,
    REG_MAX_HEIGHT = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_WR, OP_RD, OP_PX, OP_PZ, OP_DEN, OP_PY, OP_SX,
    OP_SZ, OP_SQX, OP_SQZ, OP_SQRT, OP_NX, OP_NY, OP_NZ, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CALC, S_WAIT, S_EMIT
  } state_t;

  typedef struct packed {
    op_t           op;
    logic [VW-1:0] col;
    logic [VW-1:0] row;
    logic [2:0]    tap;
    logic [HW-1:0] wdata;
    logic          last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

  localparam int NSTEPS = 12;

  // Arithmetic program run for every vertex.
  function automatic op_t step_op(input logic [3:0] s);
    op_t o;
    unique case (s)
      4'd0:    o = OP_PX;
      4'd1:    o = OP_PZ;
      4'd2:    o = OP_DEN;
      4'd3:    o = OP_PY;
      4'd4:    o = OP_SX;
      4'd5:    o = OP_SZ;
      4'd6:    o = OP_SQX;
      4'd7:    o = OP_SQZ;
      4'd8:    o = OP_SQRT;
      4'd9:    o = OP_NX;
      4'd10:   o = OP_NY;
      4'd11:   o = OP_NZ;
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  // Operations that run on the multi-cycle divider or square root.
  function automatic logic is_long(input op_t o);
    return (o == OP_SX) || (o == OP_SZ) || (o == OP_SQRT) ||
           (o == OP_NX) || (o == OP_NY) || (o == OP_NZ);
  endfunction

  // Remainder modulo 3 by summing base-4 digits.
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/hvn_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hvn_in_if;
  import hvn_pkg::*;
  logic          valid;
  logic          ready;
  logic [HW-1:0] height;
  logic          frame_start;
  modport source(output valid, height, frame_start, input ready);
  modport sink(input valid, height, frame_start, output ready);
endinterface

interface hvn_out_if;
  import hvn_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VW-1:0]         vtx_col;
  logic [VW-1:0]         vtx_row;
  logic [PXW-1:0]        pos_x;
  logic [PYW-1:0]        pos_y;
  logic [PXW-1:0]        pos_z;
  logic signed [NW-1:0]  norm_x;
  logic [NYW-1:0]        norm_y;
  logic signed [NW-1:0]  norm_z;
  logic                  last_of_run;
  modport source(output valid, vtx_col, vtx_row, pos_x, pos_y, pos_z, norm_x, norm_y,
                 norm_z, last_of_run, input ready);
  modport sink(input valid, vtx_col, vtx_row, pos_x, pos_y, pos_z, norm_x, norm_y,
               norm_z, last_of_run, output ready);
endinterface

interface hvn_cfg_if;
  import hvn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/hvn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/hvn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hvn_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [hvn_pkg::HW-1:0]   in_height,
  input  logic                     in_frame_start,
  output logic                     in_ready,
  output hvn_pkg::cmd_t            cmd,
  input  hvn_pkg::status_t         status
);
  import hvn_pkg::*;

  state_t        state_r, state_nxt;
  logic [TW-1:0] cur_col_r, cur_col_nxt;
  logic [TW-1:0] cur_row_r, cur_row_nxt;
  logic [TW-1:0] t_col_r, t_col_nxt;
  logic [TW-1:0] t_row_r, t_row_nxt;
  logic [1:0]    ci_r, ci_nxt;
  logic [1:0]    ri_r, ri_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [1:0]    nc_c, nr_c;
  logic [TW-1:0] tc_c, tr_c;
  op_t           op_c;

  // Number of vertex indices completed by a tile index along one axis.
  function automatic logic [1:0] run_len(input logic [TW-1:0] t);
    if (t == TW'(CHUNK - 1)) return 2'd3;
    if (t != '0) return 2'd1;
    return 2'd0;
  endfunction

  // First vertex index completed by a tile index.
  function automatic logic [VW-1:0] run_base(input logic [TW-1:0] t);
    if (t == TW'(CHUNK - 1)) return VW'(CHUNK - 2);
    return VW'(t) - VW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_col_r <= t_col_nxt;
    t_row_r <= t_row_nxt;
    ci_r    <= ci_nxt;
    ri_r    <= ri_nxt;
    k_r     <= k_nxt;
    step_r  <= step_nxt;
  end

  assign nc_c = run_len(t_col_r);
  assign nr_c = run_len(t_row_r);
  assign tc_c = in_frame_start ? '0 : cur_col_r;
  assign tr_c = in_frame_start ? '0 : cur_row_r;
  assign op_c = step_op(step_r);

  // Sequencer: sample write, neighbor reads, arithmetic program, emit.
  always_comb begin
    state_nxt   = state_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    t_col_nxt   = t_col_r;
    t_row_nxt   = t_row_r;
    ci_nxt      = ci_r;
    ri_nxt      = ri_r;
    k_nxt       = k_r;
    step_nxt    = step_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NOP;
    cmd.col     = run_base(t_col_r) + VW'(ci_r);
    cmd.row     = run_base(t_row_r) + VW'(ri_r);
    cmd.tap     = k_r;
    cmd.wdata   = in_height;
    cmd.last    = (ci_r == nc_c - 2'd1) && (ri_r == nr_c - 2'd1);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.col  = VW'(tc_c);
        cmd.row  = VW'(tr_c);
        cmd.tap  = TAP_H;
        if (in_valid) begin
          cmd.op    = OP_WR;
          t_col_nxt = tc_c;
          t_row_nxt = tr_c;
          ci_nxt    = '0;
          ri_nxt    = '0;
          k_nxt     = '0;
          if (tc_c == TW'(CHUNK - 1)) begin
            cur_col_nxt = '0;
            cur_row_nxt = (tr_c == TW'(CHUNK - 1)) ? '0 : tr_c + TW'(1);
          end else begin
            cur_col_nxt = tc_c + TW'(1);
            cur_row_nxt = tr_c;
          end
          if (run_len(tc_c) != 2'd0 && run_len(tr_c) != 2'd0) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (k_r < 3'(NTAPS)) begin
          cmd.op = OP_RD;
          k_nxt  = k_r + 3'd1;
        end else begin
          step_nxt  = '0;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.op = op_c;
        if (is_long(op_c)) begin
          state_nxt = S_WAIT;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_WAIT: begin
        if (!status.busy) begin
          if (step_r == 4'(NSTEPS - 1)) begin
            state_nxt = S_EMIT;
          end else begin
            step_nxt  = step_r + 4'd1;
            state_nxt = S_CALC;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
          k_nxt  = '0;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
            if (ci_r == nc_c - 2'd1) begin
              ci_nxt = '0;
              ri_nxt = ri_r + 2'd1;
            end else begin
              ci_nxt = ci_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The long units only finish while the sequencer waits on them.
  a_fall_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(status.busy) |-> state_r == S_WAIT)
    else $error("arithmetic unit finished outside the wait state");

  // The vertex indices stay inside the current run.
  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (ci_r < nc_c) && (ri_r < nr_c))
    else $error("vertex index outside its run");

endmodule
`default_nettype wire

// File: rtl/hvn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hvn_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hvn_pkg::cmd_t                   cmd,
  output hvn_pkg::status_t                status,
  input  logic                            cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvn_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [hvn_pkg::VW-1:0]          out_vtx_col,
  output logic [hvn_pkg::VW-1:0]          out_vtx_row,
  output logic [hvn_pkg::PXW-1:0]         out_pos_x,
  output logic [hvn_pkg::PYW-1:0]         out_pos_y,
  output logic [hvn_pkg::PXW-1:0]         out_pos_z,
  output logic signed [hvn_pkg::NW-1:0]   out_norm_x,
  output logic [hvn_pkg::NYW-1:0]         out_norm_y,
  output logic signed [hvn_pkg::NW-1:0]   out_norm_z,
  output logic                            out_last_of_run
);
  import hvn_pkg::*;

  localparam logic [1:0] DIR_SAME = 2'd0;
  localparam logic [1:0] DIR_DEC  = 2'd1;
  localparam logic [1:0] DIR_INC  = 2'd2;

  // Reciprocal of 255 scaled by 2^32, rounded up.
  localparam int              RECIP_W   = 25;
  localparam int              PY_PW     = HW + CFG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

  // Configuration registers.
  logic [CFG_W-1:0] ts_r, mh_r, ts_eff;

  // Row store access.
  logic [TW-1:0]     ccol_c, crow_c;
  logic [ADDR_W-1:0] addr_c;
  logic [HW-1:0]     rdata;
  logic              rd_v_r;
  logic [2:0]        rd_tap_r;
  logic [HW-1:0]     tap_r [NTAPS];

  // Working values of the current vertex.
  logic signed [HW:0]   dx_c, dz_c;
  logic [HW-1:0]        mx_c, mz_c;
  logic                 negx_c, negz_c;
  logic [PXW-1:0]       pos_x_r, pos_z_r;
  logic [PYW-1:0]       pos_y_r;
  logic [HW+CFG_W-1:0]  py_n_r;
  logic [PY_PW-1:0]     py_prod;
  logic [DEN_W-1:0]     den_r;
  logic [SLOPE_W-1:0]   sx_r, sz_r;
  logic [SQ_W-1:0]      acc_r;
  logic [LEN_W-1:0]     len_r;
  logic signed [NW-1:0] norm_x_r, norm_z_r;
  logic [NYW-1:0]       norm_y_r;
  logic [VW+CFG_W-1:0]  px_prod, pz_prod;
  logic [HW+CFG_W-1:0]  hy_prod, sx_prod, sz_prod;

  // Shared restoring divider, one quotient bit per cycle.
  logic              div_busy_r, div_start;
  logic [DIV_NW-1:0] div_n_r, div_n_in, div_q_nx;
  logic [DIV_DW-1:0] div_rem_r, div_d_r, div_d_in;
  logic [DIV_DW:0]   div_sh, div_sub;
  logic              div_ge;
  logic [DIV_CW-1:0] div_cnt_r;
  op_t               div_dst_r;
  logic [NW-1:0]     div_q16;

  // Bit-pair square root, two radicand bits per cycle.
  logic              sq_busy_r;
  logic [SQ_W-1:0]   sq_v_r, sq_res_r, sq_bit_r, sq_sum, sq_res_nx;
  logic              sq_ge;
  logic [SQ_CW-1:0]  sq_cnt_r;

  // Output register.
  logic                 out_valid_r;
  logic [VW-1:0]        o_col_r, o_row_r;
  logic [PXW-1:0]       o_px_r, o_pz_r;
  logic [PYW-1:0]       o_py_r;
  logic signed [NW-1:0] o_nx_r, o_nz_r;
  logic [NYW-1:0]       o_ny_r;
  logic                 o_last_r;

  function automatic logic [TW-1:0] clamp_idx(input logic [VW-1:0] v, input logic [1:0] dir);
    logic [VW:0] x;
    x = {1'b0, v};
    if (dir == DIR_DEC) begin
      x = (v == '0) ? '0 : x - (VW+1)'(1);
    end else if (dir == DIR_INC) begin
      x = x + (VW+1)'(1);
    end
    if (x > (VW+1)'(CHUNK - 1)) x = (VW+1)'(CHUNK - 1);
    return x[TW-1:0];
  endfunction

  assign ts_eff = (ts_r == '0) ? CFG_W'(1) : ts_r;

  // Store address of the tile that a tap names.
  always_comb begin
    case (cmd.tap)
      TAP_L: begin
        ccol_c = clamp_idx(cmd.col, DIR_DEC);
        crow_c = clamp_idx(cmd.row, DIR_SAME);
      end
      TAP_R: begin
        ccol_c = clamp_idx(cmd.col, DIR_INC);
        crow_c = clamp_idx(cmd.row, DIR_SAME);
      end
      TAP_U: begin
        ccol_c = clamp_idx(cmd.col, DIR_SAME);
        crow_c = clamp_idx(cmd.row, DIR_DEC);
      end
      TAP_D: begin
        ccol_c = clamp_idx(cmd.col, DIR_SAME);
        crow_c = clamp_idx(cmd.row, DIR_INC);
      end
      default: begin
        ccol_c = clamp_idx(cmd.col, DIR_SAME);
        crow_c = clamp_idx(cmd.row, DIR_SAME);
      end
    endcase
    addr_c = ADDR_W'(mod3(8'(crow_c))) * ADDR_W'(CHUNK) + ADDR_W'(ccol_c);
  end

  hvn_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.op == OP_WR),
    .waddr (addr_c),
    .wdata (cmd.wdata),
    .raddr (addr_c),
    .rdata (rdata)
  );

  // Height differences and their magnitudes.
  assign dx_c   = $signed({1'b0, tap_r[TAP_R]}) - $signed({1'b0, tap_r[TAP_L]});
  assign dz_c   = $signed({1'b0, tap_r[TAP_D]}) - $signed({1'b0, tap_r[TAP_U]});
  assign mx_c   = dx_c[HW] ? HW'(-dx_c) : HW'(dx_c);
  assign mz_c   = dz_c[HW] ? HW'(-dz_c) : HW'(dz_c);
  assign negx_c = !dx_c[HW] && (dx_c != '0);
  assign negz_c = !dz_c[HW] && (dz_c != '0);

  assign px_prod = (VW+CFG_W)'(cmd.col) * (VW+CFG_W)'(ts_r);
  assign pz_prod = (VW+CFG_W)'(cmd.row) * (VW+CFG_W)'(ts_r);
  assign hy_prod = (HW+CFG_W)'(tap_r[TAP_H]) * (HW+CFG_W)'(mh_r);
  assign sx_prod = (HW+CFG_W)'(mx_c) * (HW+CFG_W)'(mh_r);
  assign sz_prod = (HW+CFG_W)'(mz_c) * (HW+CFG_W)'(mh_r);

  // Height over 255 by a reciprocal multiply; exact over the whole range of
  // h * max_height + 127.
  assign py_prod = PY_PW'(py_n_r) * PY_PW'(RECIP_255);

  // Dividend and divisor for each divider job.
  always_comb begin
    div_start = 1'b1;
    div_n_in  = '0;
    div_d_in  = '0;
    case (cmd.op)
      OP_SX: begin
        div_n_in = (DIV_NW'(sx_prod) << 17) + DIV_NW'(den_r);
        div_d_in = DIV_DW'({den_r, 1'b0});
      end
      OP_SZ: begin
        div_n_in = (DIV_NW'(sz_prod) << 17) + DIV_NW'(den_r);
        div_d_in = DIV_DW'({den_r, 1'b0});
      end
      OP_NX: begin
        div_n_in = (DIV_NW'(sx_r) << 15) + DIV_NW'(len_r);
        div_d_in = DIV_DW'({len_r, 1'b0});
      end
      OP_NY: begin
        div_n_in = (DIV_NW'(65536) << 15) + DIV_NW'(len_r);
        div_d_in = DIV_DW'({len_r, 1'b0});
      end
      OP_NZ: begin
        div_n_in = (DIV_NW'(sz_r) << 15) + DIV_NW'(len_r);
        div_d_in = DIV_DW'({len_r, 1'b0});
      end
      default: div_start = 1'b0;
    endcase
  end

  // One restoring step.
  assign div_sh   = {div_rem_r, div_n_r[DIV_NW-1]};
  assign div_sub  = div_sh - {1'b0, div_d_r};
  assign div_ge   = div_sh >= {1'b0, div_d_r};
  assign div_q_nx = {div_n_r[DIV_NW-2:0], div_ge};
  assign div_q16  = div_q_nx[NW-1:0];

  // One square root step.
  assign sq_sum    = sq_res_r + sq_bit_r;
  assign sq_ge     = sq_v_r >= sq_sum;
  assign sq_res_nx = sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;

  // Control state: configuration, unit busy flags, read strobe, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r        <= CFG_W'(256);
      mh_r        <= CFG_W'(256);
      div_busy_r  <= 1'b0;
      sq_busy_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_TILE_SIZE) ts_r <= cfg_data;
      if (cfg_we && cfg_index == REG_MAX_HEIGHT) mh_r <= cfg_data;
      rd_v_r <= (cmd.op == OP_RD);
      if (div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && div_cnt_r == DIV_CW'(1)) begin
        div_busy_r <= 1'b0;
      end
      if (cmd.op == OP_SQRT) begin
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r && sq_cnt_r == SQ_CW'(1)) begin
        sq_busy_r <= 1'b0;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_tap_r <= cmd.tap;
    if (rd_v_r) tap_r[rd_tap_r] <= rdata;
    if (cmd.op == OP_PX)  pos_x_r <= px_prod[PXW-1:0];
    if (cmd.op == OP_PZ)  pos_z_r <= pz_prod[PXW-1:0];
    if (cmd.op == OP_DEN) begin
      den_r  <= DEN_W'(ts_eff) * DEN_W'(510);
      py_n_r <= hy_prod + (HW+CFG_W)'(127);
    end
    if (cmd.op == OP_PY)  pos_y_r <= py_prod[32 +: PYW];
    if (cmd.op == OP_SQX) acc_r   <= SQ_W'(sx_r) * SQ_W'(sx_r) + (SQ_W'(1) << 32);
    if (cmd.op == OP_SQZ) acc_r   <= acc_r + SQ_W'(sz_r) * SQ_W'(sz_r);

    // Divider iterations, result written to the job's destination.
    if (div_start) begin
      div_n_r   <= div_n_in;
      div_d_r   <= div_d_in;
      div_rem_r <= '0;
      div_cnt_r <= DIV_CW'(DIV_NW);
      div_dst_r <= cmd.op;
    end else if (div_busy_r) begin
      div_n_r   <= div_q_nx;
      div_rem_r <= div_ge ? div_sub[DIV_DW-1:0] : div_sh[DIV_DW-1:0];
      div_cnt_r <= div_cnt_r - DIV_CW'(1);
      if (div_cnt_r == DIV_CW'(1)) begin
        case (div_dst_r)
          OP_SX:   sx_r     <= div_q_nx[SLOPE_W-1:0];
          OP_SZ:   sz_r     <= div_q_nx[SLOPE_W-1:0];
          OP_NX:   norm_x_r <= negx_c ? -$signed(div_q16) : $signed(div_q16);
          OP_NY:   norm_y_r <= div_q_nx[NYW-1:0];
          OP_NZ:   norm_z_r <= negz_c ? -$signed(div_q16) : $signed(div_q16);
          default: ;
        endcase
      end
    end

    // Square root iterations.
    if (cmd.op == OP_SQRT) begin
      sq_v_r   <= acc_r;
      sq_res_r <= '0;
      sq_bit_r <= SQ_W'(1) << (SQ_W - 2);
      sq_cnt_r <= SQ_CW'(SQ_STEPS);
    end else if (sq_busy_r) begin
      sq_v_r   <= sq_ge ? sq_v_r - sq_sum : sq_v_r;
      sq_res_r <= sq_res_nx;
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= sq_cnt_r - SQ_CW'(1);
      if (sq_cnt_r == SQ_CW'(1)) len_r <= sq_res_nx[LEN_W-1:0];
    end

    // Output beat payload.
    if (cmd.op == OP_EMIT) begin
      o_col_r  <= cmd.col;
      o_row_r  <= cmd.row;
      o_px_r   <= pos_x_r;
      o_py_r   <= pos_y_r;
      o_pz_r   <= pos_z_r;
      o_nx_r   <= norm_x_r;
      o_ny_r   <= norm_y_r;
      o_nz_r   <= norm_z_r;
      o_last_r <= cmd.last;
    end
  end

  assign status.busy     = div_busy_r | sq_busy_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_vtx_col     = o_col_r;
  assign out_vtx_row     = o_row_r;
  assign out_pos_x       = o_px_r;
  assign out_pos_y       = o_py_r;
  assign out_pos_z       = o_pz_r;
  assign out_norm_x      = o_nx_r;
  assign out_norm_y      = o_ny_r;
  assign out_norm_z      = o_nz_r;
  assign out_last_of_run = o_last_r;

  // A new job never lands on a unit that is still iterating.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (div_start || cmd.op == OP_SQRT) |-> !(div_busy_r || sq_busy_r))
    else $error("arithmetic job started while a unit was busy");

  // The divider and the square root never run together.
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy_r && sq_busy_r))
    else $error("divider and square root busy at once");

  // A beat is loaded only when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule
`default_nettype wire

// File: rtl/heightmap_vertex_normal_gen.sv
// Heightmap vertex and normal generator.
// The in_ch channel takes one 8-bit tile height per beat in raster order; a beat
// with frame_start set is placed at tile (0,0) of a new map. The out_ch channel
// gives grid vertices with position (Q14.8 for x and z, Q8.8 for y) and unit
// normal (Q1.14); last_of_run marks the final vertex caused by one input beat.
// The cfg_ch channel writes tile_size (index 0) and max_height (index 1) and is
// always ready. An input beat that completes no vertex is only stored. Otherwise
// each vertex takes row store reads of its neighbor taps, six multiply steps,
// five jobs on the shared bit-serial divider, one square root job and an emit
// step; up to nine vertices follow one beat, and a new beat is taken only once
// the last of them is emitted. The divider runs one quotient bit per cycle.
// Reset clears the map position to (0,0), sets both registers to 256 and
// empties the output register; the row store keeps no reset state.
// When the receiver stalls, the finished vertex waits in the output register
// and the next one is computed behind it, then held until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_vertex_normal_gen (
  input  logic       clk,
  input  logic       rst_n,
  hvn_in_if.sink     in_ch,
  hvn_out_if.source  out_ch,
  hvn_cfg_if.sink    cfg_ch
);
  import hvn_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  hvn_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_height      (in_ch.height),
    .in_frame_start (in_ch.frame_start),
    .in_ready       (in_ch.ready),
    .cmd            (cmd),
    .status         (status)
  );

  hvn_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_ch.valid & cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_vtx_col     (out_ch.vtx_col),
    .out_vtx_row     (out_ch.vtx_row),
    .out_pos_x       (out_ch.pos_x),
    .out_pos_y       (out_ch.pos_y),
    .out_pos_z       (out_ch.pos_z),
    .out_norm_x      (out_ch.norm_x),
    .out_norm_y      (out_ch.norm_y),
    .out_norm_z      (out_ch.norm_z),
    .out_last_of_run (out_ch.last_of_run)
  );

endmodule
`default_nettype wire

// File: tb/heightmap_vertex_normal_gen_tb.sv
`timescale 1ns / 1ps
module heightmap_vertex_normal_gen_tb;
  import hvn_pkg::*;

  localparam int RAND_ITEMS  = 150;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 50;

  typedef struct {
    bit [VW-1:0]  col;
    bit [VW-1:0]  row;
    bit [PXW-1:0] px;
    bit [PYW-1:0] py;
    bit [PXW-1:0] pz;
    bit [NW-1:0]  nx;
    bit [NYW-1:0] ny;
    bit [NW-1:0]  nz;
    bit           last;
  } vertex_t;

  // Mesh predictor and store of pending vertices.
  class mesh_scoreboard;
    bit [HW-1:0]     heights[DEPTH];
    int              col_pos;
    int              row_pos;
    longint unsigned tile_sz;
    longint unsigned max_ht;
    vertex_t         pending[$];
    int              errors;

    function new();
      col_pos = 0;
      row_pos = 0;
      tile_sz = 256;
      max_ht  = 256;
      errors  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [CFG_W-1:0] v);
      if (idx == REG_TILE_SIZE) tile_sz = v;
      else if (idx == REG_MAX_HEIGHT) max_ht = v;
    endfunction

    function longint unsigned tile_at(int c, int r);
      int cc;
      int rr;
      cc = (c < 0) ? 0 : (c >= CHUNK) ? CHUNK - 1 : c;
      rr = (r < 0) ? 0 : (r >= CHUNK) ? CHUNK - 1 : r;
      return heights[(rr % 3) * CHUNK + cc];
    endfunction

    // Q.16 slope magnitude for a raw height difference.
    function longint unsigned slope(longint unsigned m);
      longint unsigned ts;
      longint unsigned den;
      longint unsigned num;
      ts  = (tile_sz == 0) ? 1 : tile_sz;
      den = 510 * ts;
      num = m * max_ht * 65536;
      return (2 * num + den) / (2 * den);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res;
      longint unsigned t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (t * t <= v) res = t;
      end
      return res;
    endfunction

    function bit [NW-1:0] unit_comp(longint unsigned mag, bit neg, longint unsigned len);
      longint unsigned q;
      q = (2 * mag * 16384 + len) / (2 * len);
      return neg ? NW'(-q) : NW'(q);
    endfunction

    function void add_vertex(int c, int r);
      vertex_t         v;
      longint unsigned h;
      longint          dx;
      longint          dz;
      longint unsigned sx;
      longint unsigned sz;
      longint unsigned len;
      h   = tile_at(c, r);
      dx  = longint'(tile_at(c + 1, r)) - longint'(tile_at(c - 1, r));
      dz  = longint'(tile_at(c, r + 1)) - longint'(tile_at(c, r - 1));
      sx  = slope((dx < 0) ? -dx : dx);
      sz  = slope((dz < 0) ? -dz : dz);
      len = root(sx * sx + (64'd1 << 32) + sz * sz);
      v.col  = c;
      v.row  = r;
      v.px   = PXW'(longint'(c) * tile_sz);
      v.py   = PYW'((2 * h * max_ht + 255) / 510);
      v.pz   = PXW'(longint'(r) * tile_sz);
      v.nx   = unit_comp(sx, dx > 0 && sx != 0, len);
      v.ny   = NYW'(unit_comp(65536, 1'b0, len));
      v.nz   = unit_comp(sz, dz > 0 && sz != 0, len);
      v.last = 1'b0;
      pending.push_back(v);
    endfunction

    // Vertex indices completed along one axis by tile index t.
    function int done_axis(int t, output int l[3]);
      if (t >= CHUNK - 1) begin
        l[0] = CHUNK - 2;
        l[1] = CHUNK - 1;
        l[2] = CHUNK;
        return 3;
      end
      l[0] = t - 1;
      return (t >= 1) ? 1 : 0;
    endfunction

    function void note_input(bit [HW-1:0] h, bit fs);
      int cl[3];
      int rl[3];
      int nc;
      int nr;
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      heights[(row_pos % 3) * CHUNK + col_pos] = h;
      nc = done_axis(col_pos, cl);
      nr = done_axis(row_pos, rl);
      for (int i = 0; i < nr; i++)
        for (int j = 0; j < nc; j++) add_vertex(cl[j], rl[i]);
      if (nc * nr > 0) pending[$].last = 1'b1;
      col_pos++;
      if (col_pos >= CHUNK) begin
        col_pos = 0;
        row_pos = (row_pos + 1) % CHUNK;
      end
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex, expected none, actual col %0d row %0d",
                 $time, a.col, a.row);
        return;
      end
      e = pending.pop_front();
      cmp("vtx_col", e.col, a.col);
      cmp("vtx_row", e.row, a.row);
      cmp("pos_x", e.px, a.px);
      cmp("pos_y", e.py, a.py);
      cmp("pos_z", e.pz, a.pz);
      cmp("norm_x", e.nx, a.nx);
      cmp("norm_y", e.ny, a.ny);
      cmp("norm_z", e.nz, a.nz);
      cmp("last_of_run", e.last, a.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hvn_in_if  in_ch();
  hvn_out_if out_ch();
  hvn_cfg_if cfg_ch();

  heightmap_vertex_normal_gen dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  mesh_scoreboard sb = new();

  int rx_mode;
  int stall_left;
  int quiet_cycles;
  bit bursty;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: check every vertex beat and stall on its own pattern.
  always @(posedge clk) begin
    vertex_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.col  = out_ch.vtx_col;
      a.row  = out_ch.vtx_row;
      a.px   = out_ch.pos_x;
      a.py   = out_ch.pos_y;
      a.pz   = out_ch.pos_z;
      a.nx   = out_ch.norm_x;
      a.ny   = out_ch.norm_y;
      a.nz   = out_ch.norm_z;
      a.last = out_ch.last_of_run;
      sb.check(a);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
      if (rx_mode == 2 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one height beat, with burst gaps when the sender is bursty.
  task automatic send_height(bit [HW-1:0] h, bit fs);
    if (bursty && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.height      <= h;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(h, fs);
  endtask

  // Wait until every vertex has come out and the block has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_beat(reg_idx_t idx, bit [CFG_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, v);
  endtask

  task automatic write_regs(bit [CFG_W-1:0] ts, bit [CFG_W-1:0] mh);
    cfg_beat(REG_TILE_SIZE, ts);
    cfg_beat(REG_MAX_HEIGHT, mh);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic bit [HW-1:0] pick_height();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return HW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 1;
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int sent;
    int seg;
    in_ch.valid       = 1'b0;
    in_ch.height      = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TILE_SIZE;
    cfg_ch.data       = '0;
    rx_mode      = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    bursty       = 1'b0;
    burst_left   = 0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Opening rows of one map: a random row, then two rows of alternating
    // extremes under changed register settings. The last column of the second and
    // third rows gives the three-vertex runs.
    for (int r = 0; r < 3; r++) begin
      if (r == 1) begin
        drain();
        write_regs(1, 16'hFFFF);
      end else if (r == 2) begin
        drain();
        write_regs(0, 16'hFFFF);
      end
      rx_mode = r;
      bursty  = r != 0;
      for (int c = 0; c < CHUNK; c++) begin
        if (r == 1) send_height((c % 2) ? 8'hFF : 8'h00, 1'b0);
        else if (r == 2) send_height((c % 2) ? 8'h00 : 8'hFF, 1'b0);
        else send_height(pick_height(), c == 0);
      end
    end

    // Random segments: mostly fresh maps with random content, some continued
    // walks and stray frame starts in the middle.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      if ($urandom_range(0, 1)) write_regs(pick_reg(), pick_reg());
      rx_mode = $urandom_range(0, 2);
      bursty  = $urandom_range(0, 2) != 0;
      seg = $urandom_range(20, 130);
      for (int i = 0; i < seg; i++) begin
        send_height(pick_height(),
                    (i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 49) == 0);
        sent++;
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hvn_pkg.sv
rtl/hvn_if.sv
rtl/hvn_ram.sv
rtl/hvn_ctrl.sv
rtl/hvn_dp.sv
rtl/heightmap_vertex_normal_gen.sv
tb/heightmap_vertex_normal_gen_tb.sv
